FILE: rtl/mpgn_pkg.sv
// Shared package of the page-to-gray nibble stream core.
// Holds command and register codes, panel byte constants and the item and burst types.
// Used by every module of the block.
package mpgn_pkg;

	localparam logic [1:0] CMD_SET_WINDOW = 2'd0;
	localparam logic [1:0] CMD_PIXEL      = 2'd1;
	localparam logic [1:0] CMD_NEXT_PAGE  = 2'd2;

	localparam logic [1:0] CFG_GRAY_LEVEL   = 2'd0;
	localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [3:0] GRAY_LEVEL_RST   = 4'd15;
	localparam logic [7:0] PANEL_WIDTH_RST  = 8'd128;
	localparam logic [7:0] PANEL_HEIGHT_RST = 8'd64;

	localparam logic [7:0] COL_WINDOW_CMD = 8'h15;
	localparam logic [7:0] ROW_WINDOW_CMD = 8'h75;

	localparam logic [2:0] WINDOW_LAST_IDX = 3'd5;
	localparam logic [2:0] DATA_LAST_IDX   = 3'd7;

	typedef struct packed {
		logic [1:0] command;
		logic [6:0] col_start;
		logic [3:0] page_row;
		logic [7:0] width_req;
		logic [7:0] pixel_byte;
	} item_t;

	// A window burst uses p0..p3 as start/2, end/2, first row and last row.
	// A data burst uses p0 as the left column and p1 as the right column.
	typedef struct packed {
		logic       is_window;
		logic [7:0] p0;
		logic [7:0] p1;
		logic [7:0] p2;
		logic [7:0] p3;
		logic [3:0] gray;
	} burst_t;

endpackage

FILE: rtl/mpgn_if.sv
// Valid/ready channel interfaces for the input items and the panel byte results.
// Standalone; no package needed.
interface mpgn_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [6:0] col_start;
	logic [3:0] page_row;
	logic [7:0] width_req;
	logic [7:0] pixel_byte;

	modport source (output valid, command, col_start, page_row, width_req, pixel_byte,
		input ready);
	modport sink (input valid, command, col_start, page_row, width_req, pixel_byte,
		output ready);
endinterface

interface mpgn_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       frame_start;
	logic       last_of_run;

	modport source (output valid, out_byte, is_data, frame_start, last_of_run, input ready);
	modport sink (input valid, out_byte, is_data, frame_start, last_of_run, output ready);
endinterface

FILE: rtl/mpgn_ctrl.sv
// Window and column state of the converter, with the configuration registers.
// Turns one accepted item into a burst descriptor; depends on mpgn_pkg.
module mpgn_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mpgn_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [mpgn_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                   accept,
	input  mpgn_pkg::item_t                        item,
	output logic                                   has_burst,
	output mpgn_pkg::burst_t                       burst
);
	import mpgn_pkg::*;

	logic [3:0] gray_level_q;
	logic [7:0] panel_width_q;
	logic [7:0] panel_height_q;

	logic [6:0] window_col_q;
	logic [3:0] window_page_q;
	logic [7:0] window_req_width_q;
	logic [7:0] window_clip_width_q;
	logic [7:0] held_left_byte_q;
	logic [7:0] column_pos_q;

	logic       is_window;
	logic       is_pixel;
	logic [6:0] col;
	logic [3:0] page;
	logic [7:0] req;
	logic [7:0] col_limit;
	logic [7:0] row_limit;
	logic [8:0] end_raw;
	logic [7:0] end_col;
	logic [7:0] row0;
	logic [7:0] row_end_raw;
	logic [7:0] row_end;
	logic [8:0] clip_sum;
	logic [7:0] clip;
	logic       odd;
	logic       at_end;
	logic [8:0] last_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_level_q   <= GRAY_LEVEL_RST;
			panel_width_q  <= PANEL_WIDTH_RST;
			panel_height_q <= PANEL_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRAY_LEVEL:   gray_level_q   <= cfg_wdata[3:0];
				CFG_PANEL_WIDTH:  panel_width_q  <= cfg_wdata;
				CFG_PANEL_HEIGHT: panel_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_window = (item.command == CMD_SET_WINDOW) || (item.command == CMD_NEXT_PAGE);
		is_pixel  = (item.command == CMD_PIXEL);
		if (item.command == CMD_NEXT_PAGE) begin
			col  = window_col_q;
			page = window_page_q + 4'd1;
			req  = window_req_width_q;
		end else begin
			col  = item.col_start;
			page = item.page_row;
			req  = item.width_req;
		end
		col_limit = panel_width_q - 8'd1;
		row_limit = panel_height_q - 8'd1;
		if (req != 8'd0) begin
			end_raw = {2'b00, col} + {1'b0, req} - 9'd1;
		end else begin
			end_raw = {1'b0, col_limit};
		end
		end_col     = (end_raw > {1'b0, col_limit}) ? col_limit : end_raw[7:0];
		row0        = {1'b0, page, 3'b000};
		row_end_raw = row0 + 8'd7;
		row_end     = (row_end_raw > row_limit) ? row_limit : row_end_raw;
		clip_sum    = {1'b0, end_col} - {2'b00, col} + 9'd1;
		clip        = (end_col >= {1'b0, col}) ? clip_sum[7:0] : 8'd0;

		odd      = column_pos_q[0];
		last_col = {2'b00, window_col_q} + {1'b0, window_clip_width_q} - 9'd1;
		at_end   = (window_clip_width_q != 8'd0) && ({1'b0, column_pos_q} == last_col);

		has_burst = is_window || (is_pixel && (odd || at_end));

		burst.is_window = is_window;
		burst.gray      = gray_level_q;
		if (is_window) begin
			burst.p0 = {2'b00, col[6:1]};
			burst.p1 = {1'b0, end_col[7:1]};
			burst.p2 = row0;
			burst.p3 = row_end;
		end else begin
			burst.p0 = odd ? held_left_byte_q : item.pixel_byte;
			burst.p1 = odd ? item.pixel_byte : 8'd0;
			burst.p2 = 8'd0;
			burst.p3 = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_col_q        <= '0;
			window_page_q       <= '0;
			window_req_width_q  <= '0;
			window_clip_width_q <= '0;
			held_left_byte_q    <= '0;
			column_pos_q        <= '0;
		end else if (accept) begin
			if (is_window) begin
				window_col_q        <= col;
				window_page_q       <= page;
				window_req_width_q  <= req;
				window_clip_width_q <= clip;
				held_left_byte_q    <= '0;
				column_pos_q        <= {1'b0, col};
			end else if (is_pixel) begin
				held_left_byte_q <= (!odd && !at_end) ? item.pixel_byte : 8'd0;
				column_pos_q     <= column_pos_q + 8'd1;
			end
		end
	end

endmodule

FILE: rtl/mpgn_serial.sv
// Burst register and output register that send one panel byte per cycle while the output is not stalled.
// Expands a window or data burst into bytes; depends on mpgn_pkg and mpgn_out_if.
module mpgn_serial (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              burst_load,
	input  mpgn_pkg::burst_t  burst,
	output logic              burst_free,
	mpgn_out_if.source        out_ch
);
	import mpgn_pkg::*;

	logic       burst_valid_s1;
	burst_t     burst_s1;
	logic [2:0] idx_q;

	logic       out_valid_s2;
	logic [7:0] out_byte_s2;
	logic       is_data_s2;
	logic       frame_start_s2;
	logic       last_of_run_s2;

	logic       step;
	logic       is_last;
	logic [7:0] cur_byte;

	always_comb begin
		is_last = (idx_q == (burst_s1.is_window ? WINDOW_LAST_IDX : DATA_LAST_IDX));
		step    = burst_valid_s1 && (!out_valid_s2 || out_ch.ready);
		burst_free = !burst_valid_s1 || (step && is_last);
		if (burst_s1.is_window) begin
			case (idx_q)
				3'd0:    cur_byte = COL_WINDOW_CMD;
				3'd1:    cur_byte = burst_s1.p0;
				3'd2:    cur_byte = burst_s1.p1;
				3'd3:    cur_byte = ROW_WINDOW_CMD;
				3'd4:    cur_byte = burst_s1.p2;
				3'd5:    cur_byte = burst_s1.p3;
				default: cur_byte = 8'd0;
			endcase
		end else begin
			cur_byte = {burst_s1.p1[idx_q] ? burst_s1.gray : 4'd0,
				burst_s1.p0[idx_q] ? burst_s1.gray : 4'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_s1 <= 1'b0;
			idx_q          <= '0;
		end else if (burst_load) begin
			burst_valid_s1 <= 1'b1;
			idx_q          <= '0;
		end else if (step) begin
			burst_valid_s1 <= !is_last;
			idx_q          <= is_last ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (burst_load) begin
			burst_s1 <= burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (step) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_s2    <= cur_byte;
			is_data_s2     <= !burst_s1.is_window;
			frame_start_s2 <= burst_s1.is_window && (idx_q == 3'd0);
			last_of_run_s2 <= is_last;
		end
	end

	assign out_ch.valid       = out_valid_s2;
	assign out_ch.out_byte    = out_byte_s2;
	assign out_ch.is_data     = is_data_s2;
	assign out_ch.frame_start = frame_start_s2;
	assign out_ch.last_of_run = last_of_run_s2;

`ifndef SYNTHESIS
	a_idle_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!burst_valid_s1 |-> idx_q == 3'd0)
		else $error("Burst index not cleared while no burst is held.");

	a_window_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid_s1 && burst_s1.is_window |-> idx_q <= WINDOW_LAST_IDX)
		else $error("Window burst index ran past the last command byte.");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		step && !is_last |=> burst_valid_s1)
		else $error("Burst dropped before its last byte.");

	a_frame_start_first: assert property (@(posedge clk) disable iff (!arst_n)
		step && burst_s1.is_window && idx_q == 3'd0 |=> out_valid_s2 && frame_start_s2)
		else $error("First window byte not flagged as frame start.");
`endif

endmodule

FILE: rtl/mono_page_to_gray_nibble_stream_core.sv
// Top level of the page-to-gray nibble stream converter.
// Depends on mpgn_pkg, mpgn_if, mpgn_ctrl and mpgn_serial.
//
//   Channel   Direction  Carries
//   in_ch     sink       command, col_start, page_row, width_req, pixel_byte
//   out_ch    source     out_byte, is_data, frame_start, last_of_run
//   cfg       write      cfg_we, cfg_index, cfg_wdata (gray level, panel width, height)
//
// A window item sends six bytes and a released column pair sends eight, one byte per cycle
// while the output is not stalled; the output byte sequencer sends them.
// Items that cause no byte are taken whenever the burst register is free.
// The next item is taken in the cycle the last byte of the current burst moves out.
// A stalled output holds its byte; reset clears the window state and loads register defaults.
module mono_page_to_gray_nibble_stream_core (
	input  logic                              clk,
	input  logic                              arst_n,
	mpgn_in_if.sink                           in_ch,
	mpgn_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [mpgn_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mpgn_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import mpgn_pkg::*;

	item_t  item;
	burst_t burst;
	logic   has_burst;
	logic   burst_free;
	logic   accept;

	assign item.command    = in_ch.command;
	assign item.col_start  = in_ch.col_start;
	assign item.page_row   = in_ch.page_row;
	assign item.width_req  = in_ch.width_req;
	assign item.pixel_byte = in_ch.pixel_byte;

	assign in_ch.ready = burst_free;
	assign accept      = in_ch.valid && burst_free;

	mpgn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (item),
		.has_burst (has_burst),
		.burst     (burst)
	);

	mpgn_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst_load (accept && has_burst),
		.burst      (burst),
		.burst_free (burst_free),
		.out_ch     (out_ch)
	);

endmodule

FILE: tb/mpgn_stream_checker.sv
// Checker for the page-to-gray nibble stream core: it watches both channels and the
// register port, predicts every panel byte and compares it with what the core sends.
// Depends on mpgn_pkg and the channel interfaces in mpgn_if.
module mpgn_stream_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	mpgn_in_if                                in_ch,
	mpgn_out_if                               out_ch,
	input  logic                              cfg_we,
	input  logic [mpgn_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mpgn_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output int                                fail_count,
	output int                                pending_bytes
);
	timeunit 1ns;
	timeprecision 1ps;
	import mpgn_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       is_data;
		logic       frame_start;
		logic       last_of_run;
	} panel_byte_t;

	panel_byte_t panel_bytes_q[$];
	int          byte_index;

	logic [3:0] gray_lvl;
	logic [7:0] panel_w;
	logic [7:0] panel_h;
	logic [6:0] win_col;
	logic [3:0] win_page;
	logic [7:0] win_req;
	logic [7:0] win_clip;
	logic [7:0] held_left;
	logic [7:0] col_pos;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t, byte %0d: %s", $time, byte_index, what);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	task automatic push_byte(input logic [7:0] value, input logic is_data,
		input logic frame_start, input logic last_of_run);
		panel_bytes_q.push_back({value, is_data, frame_start, last_of_run});
	endtask

	// The end column is computed without truncation and then limited to the panel;
	// a panel size of zero makes its limit 255.
	task automatic predict_window(input logic [6:0] col, input logic [3:0] page,
		input logic [7:0] req);
		logic [7:0] lim8;
		int col_lim, row_lim, win_end, row0, row_end;
		lim8 = panel_w - 8'd1;
		col_lim = lim8;
		lim8 = panel_h - 8'd1;
		row_lim = lim8;
		win_end = (req != 8'd0) ? int'(col) + int'(req) - 1 : col_lim;
		if (win_end > col_lim) begin
			win_end = col_lim;
		end
		row0 = int'(page) * 8;
		row_end = row0 + 7;
		if (row_end > row_lim) begin
			row_end = row_lim;
		end
		win_col = col;
		win_page = page;
		win_req = req;
		win_clip = (win_end >= int'(col)) ? 8'(win_end - int'(col) + 1) : 8'd0;
		held_left = 8'd0;
		col_pos = {1'b0, col};
		push_byte(COL_WINDOW_CMD, 1'b0, 1'b1, 1'b0);
		push_byte({2'b00, col[6:1]}, 1'b0, 1'b0, 1'b0);
		push_byte(8'(win_end >> 1), 1'b0, 1'b0, 1'b0);
		push_byte(ROW_WINDOW_CMD, 1'b0, 1'b0, 1'b0);
		push_byte(8'(row0), 1'b0, 1'b0, 1'b0);
		push_byte(8'(row_end), 1'b0, 1'b0, 1'b1);
	endtask

	task automatic predict_pixel(input logic [7:0] pix);
		logic [7:0] left, right;
		logic odd, at_end;
		int i;
		odd = col_pos[0];
		at_end = (win_clip != 8'd0) &&
			(int'(col_pos) == int'(win_col) + int'(win_clip) - 1);
		right = pix;
		if (!odd) begin
			held_left = pix;
			right = 8'd0;
		end
		if (odd || at_end) begin
			left = held_left;
			for (i = 0; i < 8; i++) begin
				push_byte({right[i] ? gray_lvl : 4'd0, left[i] ? gray_lvl : 4'd0},
					1'b1, 1'b0, i == 7);
			end
			held_left = 8'd0;
		end
		col_pos = col_pos + 8'd1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		panel_byte_t want;
		if (!arst_n) begin
			panel_bytes_q.delete();
			fail_count = 0;
			pending_bytes = 0;
			byte_index = 0;
			gray_lvl = GRAY_LEVEL_RST;
			panel_w = PANEL_WIDTH_RST;
			panel_h = PANEL_HEIGHT_RST;
			win_col = '0;
			win_page = '0;
			win_req = '0;
			win_clip = '0;
			held_left = '0;
			col_pos = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GRAY_LEVEL: gray_lvl = cfg_wdata[3:0];
					CFG_PANEL_WIDTH: panel_w = cfg_wdata;
					CFG_PANEL_HEIGHT: panel_h = cfg_wdata;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				case (in_ch.command)
					CMD_SET_WINDOW: predict_window(in_ch.col_start, in_ch.page_row,
						in_ch.width_req);
					CMD_NEXT_PAGE: predict_window(win_col, win_page + 4'd1, win_req);
					CMD_PIXEL: predict_pixel(in_ch.pixel_byte);
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (panel_bytes_q.size() == 0) begin
					report_mismatch($sformatf("byte %02h arrived with nothing expected",
						out_ch.out_byte));
				end else begin
					want = panel_bytes_q.pop_front();
					check_field("out_byte", out_ch.out_byte, want.value);
					check_field("is_data", out_ch.is_data, want.is_data);
					check_field("frame_start", out_ch.frame_start, want.frame_start);
					check_field("last_of_run", out_ch.last_of_run, want.last_of_run);
				end
				byte_index++;
			end
			pending_bytes = panel_bytes_q.size();
		end
	end

endmodule

FILE: tb/testbench.sv
// Top of the testbench for the page-to-gray nibble stream core: it drives directed and
// random item sequences under several register settings and idle patterns, and gives
// the verdict from the failure count of mpgn_stream_checker. Depends on mpgn_pkg and mpgn_if.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mpgn_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS = 12;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	int                     fail_count;
	int                     pending_bytes;
	int                     idle_pct;
	int                     stall_pct;
	int                     item_count;
	int                     idle_cycles;

	mpgn_in_if  in_ch();
	mpgn_out_if out_ch();

	mono_page_to_gray_nibble_stream_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mpgn_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_bytes (pending_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [6:0] col,
		input logic [3:0] page, input logic [7:0] wreq, input logic [7:0] pix);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.col_start <= col;
		in_ch.page_row <= page;
		in_ch.width_req <= wreq;
		in_ch.pixel_byte <= pix;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (cmd != CMD_UNUSED) begin
			item_count++;
		end
	endtask

	task automatic send_pixel(input logic [7:0] pix);
		send_item(CMD_PIXEL, 7'($urandom), 4'($urandom), 8'($urandom), pix);
	endtask

	// Stops sending until every expected byte has come out, then lets the core settle.
	task automatic quiesce();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_bytes != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_panel(input logic [3:0] gray, input logic [7:0] width,
		input logic [7:0] height);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GRAY_LEVEL;
		cfg_wdata <= {4'($urandom), gray};
		@(posedge clk);
		cfg_index <= CFG_PANEL_WIDTH;
		cfg_wdata <= width;
		@(posedge clk);
		cfg_index <= CFG_PANEL_HEIGHT;
		cfg_wdata <= height;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly a window followed by a run of columns, sometimes a page advance, with
	// some fully random items mixed in.
	task automatic run_random(input int n);
		int first_item, npix, pick, k;
		logic [6:0] col;
		logic [7:0] wreq;
		first_item = item_count;
		while (item_count - first_item < n) begin
			if ($urandom_range(99) < 80) begin
				col = ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom);
				pick = $urandom_range(99);
				if (pick < 70) begin
					wreq = 8'($urandom_range(1, 12));
				end else if (pick < 80) begin
					wreq = 8'd0;
				end else if (pick < 90) begin
					wreq = 8'($urandom_range(13, 128));
				end else begin
					wreq = 8'($urandom_range(129, 255));
				end
				send_item(CMD_SET_WINDOW, col, 4'($urandom), wreq, 8'($urandom));
				if (wreq >= 8'd1 && wreq <= 8'd14 && $urandom_range(1) == 1) begin
					npix = wreq;
				end else begin
					npix = $urandom_range(1, 14);
				end
				for (k = 0; k < npix; k++) begin
					if ($urandom_range(19) == 0) begin
						send_item(CMD_NEXT_PAGE, 7'($urandom), 4'($urandom), 8'($urandom),
							8'($urandom));
					end
					send_pixel(8'($urandom));
				end
			end else begin
				send_item(2'($urandom), 7'($urandom), 4'($urandom), 8'($urandom),
					8'($urandom));
			end
			if ($urandom_range(14) == 0) begin
				quiesce();
			end
		end
	endtask

	initial begin
		int k;
		idle_pct = 0;
		stall_pct = 0;
		item_count = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.command <= CMD_SET_WINDOW;
		in_ch.col_start <= '0;
		in_ch.page_row <= '0;
		in_ch.width_req <= '0;
		in_ch.pixel_byte <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset register values.
		send_pixel(8'hFF);
		send_pixel(8'hA5);
		send_item(CMD_SET_WINDOW, 7'd127, 4'd15, 8'd0, 8'h00);
		send_pixel(8'h81);
		send_item(CMD_NEXT_PAGE, 7'd0, 4'd0, 8'd0, 8'h00);
		send_item(CMD_SET_WINDOW, 7'd4, 4'd3, 8'd3, 8'h00);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h5A);
		send_item(CMD_SET_WINDOW, 7'd100, 4'd7, 8'd255, 8'h00);
		send_pixel(8'h3C);
		send_item(CMD_UNUSED, 7'h7F, 4'hF, 8'hFF, 8'hFF);
		send_pixel(8'hC3);
		send_item(CMD_SET_WINDOW, 7'd0, 4'd0, 8'd128, 8'h00);
		send_item(CMD_SET_WINDOW, 7'd0, 4'd8, 8'd1, 8'h00);
		send_pixel(8'h01);
		send_item(CMD_NEXT_PAGE, 7'd0, 4'd0, 8'd0, 8'h00);

		quiesce();
		set_panel(4'd10, 8'd128, 8'd128);
		run_random(PHASE_ITEMS);

		idle_pct = 58;
		quiesce();
		set_panel(4'd0, 8'd0, 8'd0);
		run_random(PHASE_ITEMS);

		// A one-column panel puts a window at column 127 past its edge, and the long
		// run of columns after it makes the column counter wrap.
		idle_pct = 0;
		stall_pct = 58;
		quiesce();
		set_panel(4'd1, 8'd1, 8'd8);
		send_item(CMD_SET_WINDOW, 7'd127, 4'($urandom), 8'($urandom), 8'($urandom));
		for (k = 0; k < 135; k++) begin
			send_pixel(8'($urandom));
		end
		run_random(PHASE_ITEMS);

		idle_pct = 18;
		stall_pct = 18;
		quiesce();
		set_panel(4'($urandom), 8'($urandom_range(1, 128)), 8'($urandom_range(8, 128)));
		run_random(PHASE_ITEMS);

		quiesce();
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: mono_page_to_gray_nibble_stream_core.f
rtl/mpgn_pkg.sv
rtl/mpgn_if.sv
rtl/mpgn_ctrl.sv
rtl/mpgn_serial.sv
rtl/mono_page_to_gray_nibble_stream_core.sv
tb/mpgn_stream_checker.sv
tb/testbench.sv
